// ----- sv/bps_pkg.sv -----
// shared types and constants for the pulse width statistics block
package bps_pkg;

  localparam int unsigned TsW = 32;
  localparam int unsigned StatW = 32;
  localparam int unsigned GapW = 16;

  localparam logic [GapW-1:0] GapLimitReset = 16'd65;
  localparam int unsigned CmdDepthDefault = 2;
  localparam int unsigned OutDepthDefault = 2;

  // one input request
  typedef struct packed {
    logic [TsW-1:0] timestamp;
    logic           level;
    logic           new_run;
  } sample_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic [TsW-1:0] ts;
    logic [TsW-1:0] step;
    logic           gap;
    logic           level;
    logic           toggle;
    logic           new_run;
  } cmd_t;

  // one result request
  typedef struct packed {
    logic [StatW-1:0] on_ends;
    logic [StatW-1:0] off_ends;
    logic [StatW-1:0] min_on;
    logic [StatW-1:0] max_on;
    logic [StatW-1:0] min_off;
    logic [StatW-1:0] max_off;
    logic [StatW-1:0] on_length_sum;
    logic [StatW-1:0] on_length_count;
    logic [StatW-1:0] off_length_sum;
    logic [StatW-1:0] off_length_count;
    logic [StatW-1:0] time_on;
    logic [StatW-1:0] time_off;
  } stat_t;

endpackage

// ----- sv/bps_fifo.sv -----
// small register queue with first-word fall-through read
module bps_fifo #(
  parameter type         T     = logic,
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  T               mem_q [Depth];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- sv/bps_front.sv -----
// front end: takes samples, tracks previous level and time, classifies
module bps_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bps_pkg::GapW-1:0] cfg_data_i,
  input  logic                     push_i,
  input  bps_pkg::sample_t         sample_i,
  input  logic                     cmd_ready_i,
  output logic                     cmd_valid_o,
  output bps_pkg::cmd_t            cmd_o
);
  import bps_pkg::*;

  logic [GapW-1:0] gap_limit_q;
  logic            prev_level_q;
  logic [TsW-1:0]  prev_time_q;
  logic [TsW-1:0]  step;
  logic            accept;

  assign accept      = push_i & cmd_ready_i;
  assign cmd_valid_o = accept;
  assign step        = sample_i.timestamp - prev_time_q;

  always_comb begin
    cmd_o.ts      = sample_i.timestamp;
    cmd_o.step    = step;
    cmd_o.gap     = step > {{(TsW-GapW){1'b0}}, gap_limit_q};
    cmd_o.level   = sample_i.level;
    cmd_o.toggle  = sample_i.level ^ prev_level_q;
    cmd_o.new_run = sample_i.new_run;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q  <= GapLimitReset;
      prev_level_q <= 1'b0;
      prev_time_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        gap_limit_q <= cfg_data_i;
      end
      if (accept) begin
        prev_level_q <= sample_i.level;
        prev_time_q  <= sample_i.timestamp;
      end
    end
  end

endmodule

// ----- sv/bps_back.sv -----
// back end: updates phase statistics and emits a snapshot per sample
module bps_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  bps_pkg::cmd_t   cmd_i,
  output logic            cmd_pop_o,
  input  logic            out_ready_i,
  output logic            out_push_o,
  output bps_pkg::stat_t  out_o
);
  import bps_pkg::*;

  typedef struct packed {
    logic [StatW-1:0] lo;
    logic [StatW-1:0] hi;
    logic [StatW-1:0] sum;
    logic [StatW-1:0] cnt;
  } phase_t;

  function automatic phase_t record_phase(logic [StatW-1:0] len, phase_t cur);
    phase_t nxt;
    nxt     = cur;
    if (cur.lo == '0 || len < cur.lo) nxt.lo = len;
    if (cur.hi == '0 || len > cur.hi) nxt.hi = len;
    nxt.sum = cur.sum + len;
    nxt.cnt = cur.cnt + StatW'(1);
    return nxt;
  endfunction

  stat_t          stats_q, stats_d;
  logic [TsW-1:0] trans_q, trans_d;
  logic [TsW-1:0] trans_eff;
  logic [TsW-1:0] phase_len;
  phase_t         on_cur, off_cur, on_nxt, off_nxt;
  logic           fire;

  assign fire       = cmd_valid_i & out_ready_i;
  assign cmd_pop_o  = fire;
  assign out_push_o = fire;
  assign out_o      = stats_d;

  // a gap forgets the last transition
  assign trans_eff = cmd_i.gap ? '0 : trans_q;
  assign phase_len = cmd_i.ts - trans_eff;

  assign on_cur  = '{lo: stats_q.min_on, hi: stats_q.max_on,
                     sum: stats_q.on_length_sum, cnt: stats_q.on_length_count};
  assign off_cur = '{lo: stats_q.min_off, hi: stats_q.max_off,
                     sum: stats_q.off_length_sum, cnt: stats_q.off_length_count};
  assign on_nxt  = record_phase(phase_len, on_cur);
  assign off_nxt = record_phase(phase_len, off_cur);

  always_comb begin
    stats_d = stats_q;
    trans_d = trans_q;
    if (cmd_i.new_run) begin
      stats_d = '0;
      trans_d = '0;
    end else begin
      trans_d = trans_eff;
      if (cmd_i.level) begin
        if (cmd_i.toggle) begin
          stats_d.off_ends = stats_q.off_ends + StatW'(1);
          if (trans_eff != '0) begin
            stats_d.min_off          = off_nxt.lo;
            stats_d.max_off          = off_nxt.hi;
            stats_d.off_length_sum   = off_nxt.sum;
            stats_d.off_length_count = off_nxt.cnt;
          end
          trans_d = cmd_i.ts;
        end
        stats_d.time_on = stats_q.time_on + cmd_i.step;
      end else begin
        if (cmd_i.toggle) begin
          stats_d.on_ends = stats_q.on_ends + StatW'(1);
          if (trans_eff != '0) begin
            stats_d.min_on          = on_nxt.lo;
            stats_d.max_on          = on_nxt.hi;
            stats_d.on_length_sum   = on_nxt.sum;
            stats_d.on_length_count = on_nxt.cnt;
          end
          trans_d = cmd_i.ts;
        end
        stats_d.time_off = stats_q.time_off + cmd_i.step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_q <= '0;
      trans_q <= '0;
    end else if (fire) begin
      stats_q <= stats_d;
      trans_q <= trans_d;
    end
  end

endmodule

// ----- sv/binary_signal_phase_statistics.sv -----
// top level: pulse width statistics for one on/off channel
// samples are registered in the command queue, results in the result queue ahead of the ports
// throughput: one sample per cycle while the result queue is not full; the back end updates once per sample
// full rises only when the command queue between front and back fills up
// reset (rst_ni low, asynchronous) clears queues and statistics, gap limit returns to 65
module binary_signal_phase_statistics #(
  parameter int unsigned CmdDepth = bps_pkg::CmdDepthDefault,
  parameter int unsigned OutDepth = bps_pkg::OutDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration: gap limit register
  input  logic                     cfg_we_i,
  input  logic [bps_pkg::GapW-1:0] cfg_data_i,
  // sample requests
  input  logic                     push,
  output logic                     full,
  input  bps_pkg::sample_t         sample_i,
  // result requests
  output logic                     empty,
  input  logic                     pop,
  output bps_pkg::stat_t           result_o
);
  import bps_pkg::*;

  // front to command queue
  logic  front_valid;
  cmd_t  front_cmd;
  logic  cmdq_full;

  // command queue to back
  logic  cmdq_empty;
  cmd_t  cmdq_cmd;
  logic  back_pop;

  // back to result queue
  logic  outq_full;
  logic  back_push;
  stat_t back_stats;

  // front: keeps previous level/time and the gap limit, classifies each sample
  bps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .sample_i    (sample_i),
    .cmd_ready_i (~cmdq_full),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  assign full = cmdq_full;

  // short queue decoupling classification from the statistics update
  bps_fifo #(
    .T     (cmd_t),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .wdata_i (front_cmd),
    .full_o  (cmdq_full),
    .pop_i   (back_pop),
    .rdata_o (cmdq_cmd),
    .empty_o (cmdq_empty)
  );

  // back: min/max/sum/count and on/off time accumulation
  bps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (~cmdq_empty),
    .cmd_i       (cmdq_cmd),
    .cmd_pop_o   (back_pop),
    .out_ready_i (~outq_full),
    .out_push_o  (back_push),
    .out_o       (back_stats)
  );

  // result queue lets the back keep going while the consumer stalls
  bps_fifo #(
    .T     (stat_t),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_push),
    .wdata_i (back_stats),
    .full_o  (outq_full),
    .pop_i   (pop),
    .rdata_o (result_o),
    .empty_o (empty)
  );

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the pulse width statistics block
module tb_top;
  import bps_pkg::*;

  // cycles without any accepted request before the run is declared hung
  localparam int unsigned WatchdogLimit = 5000;
  // length of the receiver hold-off that backs the block up
  localparam int unsigned HoldOffCycles = 250;
  // settle time after the last result
  localparam int unsigned DrainCycles = 8;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [GapW-1:0]    cfg_data = '0;
  logic               push = 1'b0;
  logic               full;
  sample_t            sample = '0;
  logic               empty;
  logic               pop = 1'b0;
  stat_t              result;

  // idling knobs, percent of cycles
  int unsigned        send_idle_pct = 0;
  int unsigned        pop_stall_pct = 0;
  int unsigned        hold_left = 0;
  int unsigned        idle_cycles = 0;
  int unsigned        mismatches = 0;

  // predicted statistics, one entry per accepted sample
  stat_t              stats_expected[$];

  // predictor state, arrays indexed by level (0 off, 1 on)
  logic [GapW-1:0]    cur_gap_limit = GapLimitReset;
  logic               last_level = 1'b0;
  logic [TsW-1:0]     last_ts = '0;
  logic [TsW-1:0]     phase_start = '0;  // 0 reads as unknown
  logic [StatW-1:0]   phase_ends[2];
  logic [StatW-1:0]   shortest[2];
  logic [StatW-1:0]   longest[2];
  logic [StatW-1:0]   length_sum[2];
  logic [StatW-1:0]   length_cnt[2];
  logic [StatW-1:0]   level_time[2];

  binary_signal_phase_statistics i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .push       (push),
    .full       (full),
    .sample_i   (sample),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    foreach (phase_ends[i]) begin
      phase_ends[i] = '0;
      shortest[i] = '0;
      longest[i] = '0;
      length_sum[i] = '0;
      length_cnt[i] = '0;
      level_time[i] = '0;
    end
  end

  // running statistics after one sample
  function automatic stat_t advance_phase_stats(input sample_t s);
    logic [TsW-1:0] step;
    logic [TsW-1:0] len;
    stat_t          st;
    if (s.new_run) begin
      phase_start = '0;
      foreach (phase_ends[i]) begin
        phase_ends[i] = '0;
        shortest[i] = '0;
        longest[i] = '0;
        length_sum[i] = '0;
        length_cnt[i] = '0;
        level_time[i] = '0;
      end
    end else begin
      step = s.timestamp - last_ts;
      if (step > cur_gap_limit) phase_start = '0;
      if (s.level != last_level) begin
        // the phase at the old level has ended
        phase_ends[last_level] += 1;
        if (phase_start != '0) begin
          len = s.timestamp - phase_start;
          // a stored 0 means unset and is always replaced
          if (shortest[last_level] == '0 || len < shortest[last_level])
            shortest[last_level] = len;
          if (longest[last_level] == '0 || len > longest[last_level])
            longest[last_level] = len;
          length_sum[last_level] += len;
          length_cnt[last_level] += 1;
        end
        phase_start = s.timestamp;
      end
      level_time[s.level] += step;
    end
    last_level = s.level;
    last_ts = s.timestamp;

    st.on_ends          = phase_ends[1];
    st.off_ends         = phase_ends[0];
    st.min_on           = shortest[1];
    st.max_on           = longest[1];
    st.min_off          = shortest[0];
    st.max_off          = longest[0];
    st.on_length_sum    = length_sum[1];
    st.on_length_count  = length_cnt[1];
    st.off_length_sum   = length_sum[0];
    st.off_length_count = length_cnt[0];
    st.time_on          = level_time[1];
    st.time_off         = level_time[0];
    return st;
  endfunction

  // offers one sample request and records its prediction once accepted
  task automatic send_sample(input logic [TsW-1:0] ts, input logic lvl, input logic nr);
    sample_t s;
    s.timestamp = ts;
    s.level = lvl;
    s.new_run = nr;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push <= 1'b1;
    sample <= s;
    do @(posedge clk); while (full);
    stats_expected.push_back(advance_phase_stats(s));
  endtask

  // waits for all results, then writes the gap limit while the block is idle
  task automatic set_gap_limit(input logic [GapW-1:0] value);
    push <= 1'b0;
    while (stats_expected.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_gap_limit = value;
  endtask

  // time step: mostly inside the gap limit, with the boundary and zero mixed in
  function automatic logic [TsW-1:0] pick_step();
    int unsigned g;
    g = cur_gap_limit;
    case ($urandom_range(9))
      0:       return '0;
      1:       return g;
      2:       return g + 1;
      3, 4:    return $urandom_range(3, 1);
      default: return $urandom_range(g, 1);
    endcase
  endfunction

  // runs of non-decreasing timestamps with random toggles, a little noise between
  task automatic send_random_items(input int unsigned count);
    int unsigned    sent;
    int unsigned    run_len;
    int unsigned    k;
    logic [TsW-1:0] ts;
    logic           lvl;
    sent = 0;
    while (sent < count) begin
      run_len = $urandom_range(40, 4);
      ts = $urandom;
      lvl = 1'($urandom_range(1, 0));
      // now and then a run carries on without its start flag
      send_sample(ts, lvl, $urandom_range(9) != 0);
      sent++;
      for (k = 1; k < run_len && sent < count; k++) begin
        if ($urandom_range(99) < 6) begin
          ts = $urandom;
          lvl = 1'($urandom_range(1, 0));
          send_sample(ts, lvl, $urandom_range(3) == 0);
        end else begin
          ts = ts + pick_step();
          if ($urandom_range(99) < 45) lvl = !lvl;
          send_sample(ts, lvl, 1'b0);
        end
        sent++;
      end
    end
  endtask

  // samples before any run start work against the reset state
  task automatic test_before_first_run();
    send_sample(32'd5, 1'b1, 1'b0);
    send_sample(32'd9, 1'b0, 1'b0);
  endtask

  // equal timestamps, zero-length phase, gap boundary, time going back, transition at 0
  task automatic test_phase_corners();
    send_sample(32'd100, 1'b0, 1'b1);
    send_sample(32'd110, 1'b1, 1'b0);
    send_sample(32'd120, 1'b0, 1'b0);
    send_sample(32'd120, 1'b1, 1'b0);
    send_sample(32'd130, 1'b0, 1'b0);
    send_sample(32'd140, 1'b1, 1'b0);
    send_sample(32'd195, 1'b0, 1'b0);
    send_sample(32'd260, 1'b1, 1'b0);
    send_sample(32'd326, 1'b0, 1'b0);
    send_sample(32'd50, 1'b1, 1'b0);
    send_sample(32'hFFFF_FFF0, 1'b0, 1'b1);
    send_sample(32'd0, 1'b1, 1'b0);
    send_sample(32'd10, 1'b0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
  endtask

  // gap limit of zero and the largest gap limit, each side of the boundary
  task automatic test_gap_limit_extremes();
    set_gap_limit('0);
    send_sample(32'd1000, 1'b1, 1'b1);
    send_sample(32'd1000, 1'b0, 1'b0);
    send_sample(32'd1000, 1'b1, 1'b0);
    send_sample(32'd1001, 1'b0, 1'b0);
    set_gap_limit('1);
    send_sample(32'd0, 1'b0, 1'b1);
    send_sample(32'd5, 1'b1, 1'b0);
    send_sample(32'd65540, 1'b0, 1'b0);
    send_sample(32'd131076, 1'b1, 1'b0);
  endtask

  task automatic test_random_traffic(input logic [GapW-1:0] gap, input int unsigned idle_pct,
                                     input int unsigned stall_pct, input int unsigned count);
    set_gap_limit(gap);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    send_random_items(count);
  endtask

  // receiver holds off while the sender keeps offering, so full must rise
  task automatic test_backpressure();
    set_gap_limit(16'd300);
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_left = HoldOffCycles;
    send_random_items(60);
  endtask

  task automatic check_field(input string name, input logic [StatW-1:0] exp_v,
                             input logic [StatW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // result side: check each accepted result, then choose the next pop
  always @(posedge clk) begin : rx_side
    stat_t want;
    if (rst_n && pop && !empty) begin
      if (stats_expected.size() == 0) begin
        $error("result with no sample waiting");
        mismatches++;
      end else begin
        want = stats_expected.pop_front();
        check_field("on_ends", want.on_ends, result.on_ends);
        check_field("off_ends", want.off_ends, result.off_ends);
        check_field("min_on", want.min_on, result.min_on);
        check_field("max_on", want.max_on, result.max_on);
        check_field("min_off", want.min_off, result.min_off);
        check_field("max_off", want.max_off, result.max_off);
        check_field("on_length_sum", want.on_length_sum, result.on_length_sum);
        check_field("on_length_count", want.on_length_count, result.on_length_count);
        check_field("off_length_sum", want.off_length_sum, result.off_length_sum);
        check_field("off_length_count", want.off_length_count, result.off_length_count);
        check_field("time_on", want.time_on, result.time_on);
        check_field("time_off", want.time_off, result.time_off);
      end
    end
    if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left--;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // watchdog: any accepted request restarts the count
  always @(posedge clk) begin
    if (rst_n && ((push && !full) || (pop && !empty))) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_before_first_run();
    test_phase_corners();
    test_gap_limit_extremes();
    test_random_traffic(GapLimitReset, 0, 0, 340);
    test_random_traffic(16'd1, 88, 0, 340);
    test_random_traffic(16'hFFFF, 0, 88, 340);
    test_random_traffic(16'($urandom_range(2000, 2)), 11, 11, 340);
    test_backpressure();

    // drain the remaining results and let the pipeline settle
    push <= 1'b0;
    while (stats_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
